// ----- hw/rtl/bcd_repeated_add_accumulator_assert.svh -----
// ----------------------------------------------------------------------------
// BCD accumulator assertion macros
// Shared property wrappers for the accumulator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BCD_REPEATED_ADD_ACCUMULATOR_ASSERT_SVH
`define BCD_REPEATED_ADD_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bra: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define BRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bra: next-cycle check failed");

`endif

// ----- hw/rtl/bra_pkg.sv -----
// ----------------------------------------------------------------------------
// bra_pkg
// Constants, control word layout and microcode for the BCD accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bra_pkg;

    localparam int DIGIT_W         = 4;
    localparam int AMT_W           = 16;
    localparam int CASC_W          = 8;
    localparam int OUT_W           = 32;
    localparam int OUT_DIGITS      = OUT_W / DIGIT_W;
    localparam int DIGITS_DEF      = 8;
    localparam int CASCADE_CAP_DEF = 7;
    localparam int PC_W            = 3;

    // Step addresses
    localparam logic [PC_W-1:0] P_IDLE   = 3'd0;
    localparam logic [PC_W-1:0] P_CHECK  = 3'd1;
    localparam logic [PC_W-1:0] P_DABBLE = 3'd2;
    localparam logic [PC_W-1:0] P_PREP   = 3'd3;
    localparam logic [PC_W-1:0] P_ADD    = 3'd4;
    localparam logic [PC_W-1:0] P_WAITO  = 3'd5;
    localparam logic [PC_W-1:0] P_EMIT   = 3'd6;
    localparam logic [PC_W-1:0] P_CLEAR  = 3'd7;

    // Datapath operations
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_DABBLE = 3'd2;
    localparam logic [2:0] OP_PREP   = 3'd3;
    localparam logic [2:0] OP_ADD    = 3'd4;
    localparam logic [2:0] OP_EMIT   = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;

    // Jump conditions
    localparam logic [2:0] C_NEVER    = 3'd0;
    localparam logic [2:0] C_ALWAYS   = 3'd1;
    localparam logic [2:0] C_NO_INPUT = 3'd2;
    localparam logic [2:0] C_IS_CLEAR = 3'd3;
    localparam logic [2:0] C_CNT_NZ   = 3'd4;
    localparam logic [2:0] C_OUT_BUSY = 3'd5;

    typedef struct packed {
        logic [2:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // Program ROM: taken jump goes to target, otherwise fall through to pc + 1.
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            P_IDLE:   w = '{op: OP_LOAD,   cond: C_NO_INPUT, target: P_IDLE};
            P_CHECK:  w = '{op: OP_NOP,    cond: C_IS_CLEAR, target: P_CLEAR};
            P_DABBLE: w = '{op: OP_DABBLE, cond: C_CNT_NZ,   target: P_DABBLE};
            P_PREP:   w = '{op: OP_PREP,   cond: C_NEVER,    target: P_IDLE};
            P_ADD:    w = '{op: OP_ADD,    cond: C_CNT_NZ,   target: P_ADD};
            P_WAITO:  w = '{op: OP_NOP,    cond: C_OUT_BUSY, target: P_WAITO};
            P_EMIT:   w = '{op: OP_EMIT,   cond: C_ALWAYS,   target: P_IDLE};
            P_CLEAR:  w = '{op: OP_CLEAR,  cond: C_ALWAYS,   target: P_WAITO};
            default:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: P_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bcd_repeated_add_accumulator.sv -----
// Flow: an add word runs CHECK, the double-dabble loop, PREP, the digit-serial add,
//   WAITO (held while the output is busy) and EMIT; e = min(cascade - 1 mod 256,
//   CASCADE_CAP). A clear word runs CHECK, CLEAR, WAITO and EMIT. One word is in flight
//   at a time; the next is accepted once the result sits in the output register.
// The double-dabble loop runs 16 + e steps and the digit-serial adder DIGITS
//   steps. Reset (aresetn low, synchronous) zeroes all digits.
// ----------------------------------------------------------------------------
// bcd_repeated_add_accumulator
// Decimal accumulator that adds amount * 2^e in BCD under microcode control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bcd_repeated_add_accumulator_assert.svh"

module bcd_repeated_add_accumulator #(
    parameter int DIGITS      = bra_pkg::DIGITS_DEF,
    parameter int CASCADE_CAP = bra_pkg::CASCADE_CAP_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire                        s_command,
    input  wire  [bra_pkg::AMT_W-1:0]  s_amount,
    input  wire  [bra_pkg::CASC_W-1:0] s_cascade,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic [bra_pkg::OUT_W-1:0]  m_score_bcd
);

    import bra_pkg::*;

    // Repeating the add 2^e times equals adding amount * 2^e once. The binary
    // amount is fed MSB first into a double-dabble converter, followed by e
    // zero bits, which yields BCD(amount * 2^e) modulo 10^DIGITS. That operand
    // is then added into the accumulator one digit per step.
    localparam int CNT_MAX = (AMT_W + CASCADE_CAP > DIGITS) ? AMT_W + CASCADE_CAP : DIGITS;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam int ACC_W   = DIGITS * DIGIT_W;

    logic [PC_W-1:0]                      pc_reg, pc_next;
    logic [DIGITS-1:0][DIGIT_W-1:0]       acc_reg, acc_next;
    logic [DIGITS-1:0][DIGIT_W-1:0]       opd_reg, opd_next;
    logic [AMT_W-1:0]                     bin_reg, bin_next;
    logic [CNT_W-1:0]                     cnt_reg, cnt_next;
    logic                                 cmd_reg, cmd_next;
    logic                                 carry_reg, carry_next;
    logic                                 m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]                     m_data_reg, m_data_next;

    ctrl_t                                ctrl;
    logic                                 jump;
    logic [CASC_W-1:0]                    casc_m1;
    logic [CASC_W-1:0]                    exp_sat;
    logic [DIGITS-1:0][DIGIT_W-1:0]       opd_adj;
    logic [ACC_W-1:0]                     opd_adj_flat;
    logic [DIGIT_W:0]                     dsum;
    logic [DIGIT_W-1:0]                   dres;
    logic                                 dcarry;
    logic [OUT_W-1:0]                     packed_acc;
    logic                                 acc_is_bcd;

    assign ctrl        = ucode(pc_reg);
    assign s_ready     = (pc_reg == P_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_score_bcd = m_data_reg;

    // Repeat exponent: cascade - 1 wraps in eight bits, then saturates at the cap.
    assign casc_m1 = s_cascade - CASC_W'(1);
    assign exp_sat = (casc_m1 > CASC_W'(CASCADE_CAP)) ? CASC_W'(CASCADE_CAP) : casc_m1;

    // Double-dabble adjust: every digit of 5 or more gets +3 before the shift.
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            opd_adj[k] = (opd_reg[k] >= DIGIT_W'(5)) ? opd_reg[k] + DIGIT_W'(3) : opd_reg[k];
        end
    end
    assign opd_adj_flat = opd_adj;

    // One decimal digit add at the low end of the rotating registers.
    assign dsum   = {1'b0, acc_reg[0]} + {1'b0, opd_reg[0]} + {{DIGIT_W{1'b0}}, carry_reg};
    assign dcarry = (dsum >= (DIGIT_W+1)'(10));
    assign dres   = dcarry ? DIGIT_W'(dsum - (DIGIT_W+1)'(10)) : dsum[DIGIT_W-1:0];

    // Low eight digits go to the port; digits that do not exist read as zero.
    always_comb begin
        packed_acc = '0;
        for (int k = 0; k < OUT_DIGITS; k++) begin
            if (k < DIGITS) begin
                packed_acc[k*DIGIT_W +: DIGIT_W] = acc_reg[k];
            end
        end
    end

    // Sequencer: evaluate the step's jump condition.
    always_comb begin
        case (ctrl.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_INPUT: jump = !s_valid;
            C_IS_CLEAR: jump = !cmd_reg;
            C_CNT_NZ:   jump = (cnt_reg != '0);
            C_OUT_BUSY: jump = m_valid_reg && !m_ready;
            default:    jump = 1'b1;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + PC_W'(1);
    end

    // Datapath driven by the control word.
    always_comb begin
        acc_next     = acc_reg;
        opd_next     = opd_reg;
        bin_next     = bin_reg;
        cnt_next     = cnt_reg;
        cmd_next     = cmd_reg;
        carry_next   = carry_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        // Drop the output flag once the word has been taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (ctrl.op)
            OP_LOAD: begin
                // Latch the input word every idle cycle; it only counts on accept.
                cmd_next = s_command;
                bin_next = s_amount;
                opd_next = '0;
                cnt_next = CNT_W'(AMT_W - 1) + CNT_W'(exp_sat);
            end
            OP_DABBLE: begin
                opd_next = {opd_adj_flat[ACC_W-2:0], bin_reg[AMT_W-1]};
                bin_next = {bin_reg[AMT_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            OP_PREP: begin
                cnt_next   = CNT_W'(DIGITS - 1);
                carry_next = 1'b0;
            end
            OP_ADD: begin
                // Rotate the sum digit in at the top; a full pass realigns the digits.
                acc_next   = {dres, acc_reg[DIGITS-1:1]};
                opd_next   = {DIGIT_W'(0), opd_reg[DIGITS-1:1]};
                carry_next = dcarry;
                cnt_next   = cnt_reg - CNT_W'(1);
            end
            OP_EMIT: begin
                m_data_next  = packed_acc;
                m_valid_next = 1'b1;
            end
            OP_CLEAR: begin
                acc_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= P_IDLE;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and work registers, no reset needed.
    always_ff @(posedge aclk) begin
        opd_reg    <= opd_next;
        bin_reg    <= bin_next;
        cnt_reg    <= cnt_next;
        cmd_reg    <= cmd_next;
        carry_reg  <= carry_next;
        m_data_reg <= m_data_next;
    end

    // Every stored digit must stay a valid decimal digit.
    always_comb begin
        acc_is_bcd = 1'b1;
        for (int k = 0; k < DIGITS; k++) begin
            if (acc_reg[k] > DIGIT_W'(9)) begin
                acc_is_bcd = 1'b0;
            end
        end
    end

    `BRA_ASSERT_IMP(a_acc_bcd, aclk, aresetn, 1'b1, acc_is_bcd)
    `BRA_ASSERT_IMP(a_emit_slot_free, aclk, aresetn, pc_reg == P_EMIT, !m_valid_reg)
    `BRA_ASSERT_NXT(a_accept_to_check, aclk, aresetn, s_valid && s_ready, pc_reg == P_CHECK)

endmodule

`default_nettype wire

// ----- bench/tb_bcd_repeated_add_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bcd_repeated_add_accumulator
// Self-checking bench for the BCD accumulator. A driver presents clear and add
// words from a queue, a monitor checks every score against a digit-serial
// decimal model kept in the bench, and both sides stall at random.
// ----------------------------------------------------------------------------

module tb_bcd_repeated_add_accumulator;

    localparam int DIGITS      = bra_pkg::DIGITS_DEF;
    localparam int CASCADE_CAP = bra_pkg::CASCADE_CAP_DEF;

    // Command codes carried on s_command.
    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_ADD   = 1'b1;

    localparam int RANDOM_WORDS = 1750;
    localparam int IDLE_PCT     = 13;
    // The limit covers the worst add with stalls many times over.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 40;
    // Window with no idling on either side.
    localparam int CALM_START   = 3000;
    localparam int CALM_END     = 9000;

    typedef struct {
        logic                      cmd;
        logic [bra_pkg::AMT_W-1:0]  amount;
        logic [bra_pkg::CASC_W-1:0] cascade;
        bit                        drain;   // hold until every score is back
    } score_word_t;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    logic                        s_command   = CMD_CLEAR;
    logic [bra_pkg::AMT_W-1:0]   s_amount    = '0;
    logic [bra_pkg::CASC_W-1:0]  s_cascade   = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    logic [bra_pkg::OUT_W-1:0]   m_score_bcd;

    score_word_t                 pending_words[$];
    logic [bra_pkg::OUT_W-1:0]   expected_scores[$];
    logic [bra_pkg::OUT_W-1:0]   oldest_score;
    logic [bra_pkg::DIGIT_W-1:0] acc_digits[DIGITS] = '{default: '0};

    int unsigned cycle_count = 0;
    int unsigned errors      = 0;
    bit          word_taken  = 1'b0;
    bit          calm;

    bcd_repeated_add_accumulator #(
        .DIGITS      (DIGITS),
        .CASCADE_CAP (CASCADE_CAP)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_amount    (s_amount),
        .s_cascade   (s_cascade),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_score_bcd (m_score_bcd)
    );

    always #5 aclk = ~aclk;

    assign calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

    // Advance the bench's own accumulator by one word and return the packed
    // score. An add repeats the amount 2^e times, each pass digit by digit with
    // decimal carry; carries and amount digits past the top digit are dropped.
    function automatic logic [bra_pkg::OUT_W-1:0] predict_score(
        input logic                       cmd,
        input logic [bra_pkg::AMT_W-1:0]  amount,
        input logic [bra_pkg::CASC_W-1:0] cascade
    );
        logic [bra_pkg::CASC_W-1:0] expo;
        logic [bra_pkg::OUT_W-1:0]  packed_val;
        int unsigned                rest;
        int unsigned                sum;
        int unsigned                carry;
        packed_val = '0;
        if (cmd == CMD_CLEAR) begin
            for (int k = 0; k < DIGITS; k++) acc_digits[k] = '0;
        end else begin
            // Cascade zero wraps to 255 here and so lands on the cap.
            expo = cascade - 8'd1;
            if (expo > CASCADE_CAP) expo = 8'(CASCADE_CAP);
            for (int r = 0; r < (1 << expo); r++) begin
                carry = 0;
                rest  = 32'(amount);
                for (int k = 0; k < DIGITS; k++) begin
                    sum   = acc_digits[k] + carry + (rest % 10);
                    rest  = rest / 10;
                    carry = (sum >= 10) ? 1 : 0;
                    acc_digits[k] = 4'(carry ? sum - 10 : sum);
                end
            end
        end
        // Only the low eight digits fit in the result word.
        for (int k = 0; k < DIGITS && k < bra_pkg::OUT_DIGITS; k++)
            packed_val[4*k +: 4] = acc_digits[k];
        return packed_val;
    endfunction

    // Monitor: sample both handshakes at the rising edge, check the oldest
    // expected score, then record the word just accepted.
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            word_taken = aresetn && s_valid && s_ready;
            if (aresetn && m_valid && m_ready) begin
                if (expected_scores.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: score with no word pending: expected none, actual %h",
                             $time, m_score_bcd);
                end else begin
                    oldest_score = expected_scores.pop_front();
                    if (m_score_bcd !== oldest_score) begin
                        errors = errors + 1;
                        $display("%0t: score mismatch: expected %h, actual %h",
                                 $time, oldest_score, m_score_bcd);
                    end
                end
            end
            if (word_taken)
                expected_scores.push_back(predict_score(s_command, s_amount, s_cascade));
        end
    end

    // Driver: change inputs at the falling edge. Hold a presented word until
    // the monitor saw it taken; otherwise present the next one or idle.
    always @(negedge aclk) begin
        score_word_t w;
        bit          hold;
        if (aresetn) begin
            hold = s_valid && !word_taken;
            if (!hold) begin
                if (pending_words.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT) &&
                    (!pending_words[0].drain || expected_scores.size() == 0)) begin
                    w = pending_words.pop_front();
                    s_valid   <= 1'b1;
                    s_command <= w.cmd;
                    s_amount  <= w.amount;
                    s_cascade <= w.cascade;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Fill the word queue, release reset, then wait for the drain.
    initial begin
        score_word_t w;
        int          r;

        // Directed part: extremes of every field, both commands, cascade zero,
        // cascade above the cap, and a run of big adds that wraps past 10^8.
        pending_words.push_back('{CMD_CLEAR, 16'd0,     8'd0,   1'b0});
        pending_words.push_back('{CMD_ADD,   16'd0,     8'd1,   1'b0});
        pending_words.push_back('{CMD_ADD,   16'hFFFF,  8'd1,   1'b0});
        pending_words.push_back('{CMD_ADD,   16'd1,     8'd0,   1'b0});
        pending_words.push_back('{CMD_ADD,   16'd12345, 8'd2,   1'b0});
        pending_words.push_back('{CMD_ADD,   16'hFFFF,  8'd8,   1'b0});
        pending_words.push_back('{CMD_ADD,   16'hFFFF,  8'd255, 1'b0});
        pending_words.push_back('{CMD_ADD,   16'd9999,  8'd7,   1'b0});
        pending_words.push_back('{CMD_CLEAR, 16'hFFFF,  8'd255, 1'b0});
        for (int i = 0; i < 13; i++)
            pending_words.push_back('{CMD_ADD, 16'hFFFF, 8'd0, 1'b0});
        pending_words.push_back('{CMD_ADD,   16'h8000,  8'h80,  1'b0});
        pending_words.push_back('{CMD_CLEAR, 16'd0,     8'd1,   1'b1});

        // Random part: mostly adds, small cascades favored so the exponent
        // sweeps below and at the cap; now and then hold for a full drain.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            w.cmd = ($urandom_range(0, 19) == 0) ? CMD_CLEAR : CMD_ADD;
            r = $urandom_range(0, 9);
            if (r == 0)      w.amount = 16'd0;
            else if (r == 1) w.amount = 16'hFFFF;
            else             w.amount = 16'($urandom);
            if ($urandom_range(0, 3) == 0) w.cascade = 8'($urandom_range(0, 255));
            else                           w.cascade = 8'($urandom_range(0, 9));
            w.drain = (i % 400 == 200);
            pending_words.push_back(w);
        end

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_valid || expected_scores.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0 && expected_scores.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/bra_pkg.sv
hw/rtl/bcd_repeated_add_accumulator.sv
bench/tb_bcd_repeated_add_accumulator.sv
